/* sv/wrecip_pkg.sv */
// ----------------------------------------------------------------------------
// Word reciprocal package
// Shared widths, types and constants for the 64-bit reciprocal pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package wrecip_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned SEED_W = 11;

  // Seed table numerator: 2^19 - 3*2^8.
  localparam int unsigned SEED_NUM = 523520;

  // The value 2^60 used by the second Newton step.
  localparam logic [WORD_W-1:0] NEWTON_ONE = 64'h1000_0000_0000_0000;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [SEED_W-1:0] seed_t;

endpackage

`default_nettype wire

/* sv/wrecip_if.sv */
// ----------------------------------------------------------------------------
// Word reciprocal channels
// Valid/ready channels for the divisor input and the reciprocal result.
// ----------------------------------------------------------------------------
`default_nettype none

interface wrecip_in_if import wrecip_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t divisor;

  modport source (output valid, output divisor, input ready);
  modport sink   (input valid, input divisor, output ready);
endinterface

interface wrecip_rcp_if import wrecip_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t reciprocal;

  modport source (output valid, output reciprocal, input ready);
  modport sink   (input valid, input reciprocal, output ready);
endinterface

`default_nettype wire

/* sv/word_reciprocal_top.sv */
// ----------------------------------------------------------------------------
// Word reciprocal
// For a normalized 64-bit divisor d (top bit set) returns
// floor((2^128-1)/d) - 2^64. An 18-stage pipeline accepts one transaction
// per clock while no stage stalls; the last stage is the output register.
// Each stage holds at most one 32x32-class multiplier bank or one wide add,
// and bubbles collapse under back-pressure, so a new divisor is taken
// whenever any stage ahead has room.
// ----------------------------------------------------------------------------
`default_nettype none

module word_reciprocal_top import wrecip_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  wrecip_in_if.sink     in_chan,
  wrecip_rcp_if.source  out_chan
);

  localparam int unsigned NSTG = 18;

  // Seed table, evaluated at elaboration.
  seed_t seed_tab [256];
  for (genvar i = 0; i < 256; i++) begin : g_seed
    localparam int unsigned SeedVal = SEED_NUM / (256 + i);
    assign seed_tab[i] = SEED_W'(SeedVal);
  end

  // Stage control: a stage may load when it is empty or the next one loads.
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] en;

  assign en[NSTG-1] = !vld_r[NSTG-1] || out_chan.ready;
  for (genvar k = 0; k < NSTG-1; k++) begin : g_en
    assign en[k] = !vld_r[k] || en[k+1];
  end

  assign vld_nxt = {vld_r[NSTG-2:0], in_chan.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_nxt[k];
        end
      end
    end
  end

  assign in_chan.ready = en[0];

  // Pipeline data registers.
  word_t       d_r   [0:16];
  logic [40:0] d40_r [0:3];
  seed_t       v0_r  [0:2];
  logic [21:0] v1_r  [3:6];
  logic [35:0] v2_r  [7:11];
  word_t       v3_r  [12:16];

  logic [21:0] sq_r;
  logic [62:0] m_r;
  logic [62:0] p_r;
  word_t       t_r;
  logic [53:0] qlo_r;
  logic [31:0] qhi_r;
  word_t       d63_r;
  logic [67:0] rlo_r;
  logic [31:0] rhi_r;
  word_t       hv_r;
  word_t       e_r;
  logic [67:0] slo_r;
  logic [67:0] shi_r;
  logic [34:0] hs_r;
  word_t       a0_r, a1_r, a2_r, a3_r;
  word_t       a0c_r, a3c_r;
  logic [64:0] mid_r;
  logic [127:0] full_r;
  word_t       hi_r;
  word_t       res_r;

  // Next values.
  logic [7:0]   seed_idx;
  seed_t        v0_nxt;
  logic [40:0]  d40_nxt;
  logic [21:0]  sq_nxt;
  logic [62:0]  m_nxt;
  logic [22:0]  v1_full;
  logic [21:0]  v1_nxt;
  logic [62:0]  p_nxt;
  word_t        t_nxt;
  logic [53:0]  qlo_nxt;
  logic [53:0]  qhi_full;
  logic [31:0]  qhi_nxt;
  word_t        q64;
  logic [35:0]  v2_nxt;
  word_t        d63_nxt;
  logic [67:0]  rlo_nxt;
  logic [67:0]  rhi_full;
  logic [31:0]  rhi_nxt;
  word_t        hv_nxt;
  word_t        e_nxt;
  logic [67:0]  slo_nxt;
  logic [67:0]  shi_nxt;
  logic [99:0]  prod;
  logic [34:0]  hs_nxt;
  word_t        v3_nxt;
  word_t        a0_nxt, a1_nxt, a2_nxt, a3_nxt;
  logic [64:0]  mid_nxt;
  logic [127:0] full_nxt;
  logic [64:0]  lo_sum;
  word_t        hi_nxt;
  word_t        res_nxt;

  always_comb begin
    // Stage 0: seed lookup.
    seed_idx = in_chan.divisor[62:55];
    v0_nxt   = seed_tab[seed_idx];
    d40_nxt  = {1'b0, in_chan.divisor[63:24]} + 41'd1;

    // Stages 1 to 3: first Newton step.
    sq_nxt  = {11'b0, v0_r[0]} * {11'b0, v0_r[0]};
    m_nxt   = {41'b0, sq_r} * {22'b0, d40_r[1]};
    v1_full = {1'b0, v0_r[2], 11'b0} - m_r[62:40] - 23'd1;
    v1_nxt  = v1_full[21:0];

    // Stages 4 to 7: second Newton step, everything modulo 2^64.
    p_nxt    = {41'b0, v1_r[3]} * {22'b0, d40_r[3]};
    t_nxt    = NEWTON_ONE - {1'b0, p_r};
    qlo_nxt  = {22'b0, t_r[31:0]} * {32'b0, v1_r[5]};
    qhi_full = {22'b0, t_r[63:32]} * {32'b0, v1_r[5]};
    qhi_nxt  = qhi_full[31:0];
    q64      = {10'b0, qlo_r} + {qhi_r, 32'b0};
    v2_nxt   = {1'b0, v1_r[6], 13'b0} + {19'b0, q64[63:47]};
    d63_nxt  = {1'b0, d_r[6][63:1]} + {63'b0, d_r[6][0]};

    // Stages 8 to 12: third step with the odd-divisor correction.
    rlo_nxt  = {32'b0, v2_r[7]} * {36'b0, d63_r[31:0]};
    rhi_full = {32'b0, v2_r[7]} * {36'b0, d63_r[63:32]};
    rhi_nxt  = rhi_full[31:0];
    hv_nxt   = {64{d_r[7][0]}} & {29'b0, v2_r[7][35:1]};
    e_nxt    = hv_r - rlo_r[63:0] - {rhi_r, 32'b0};
    slo_nxt  = {32'b0, v2_r[9]} * {36'b0, e_r[31:0]};
    shi_nxt  = {32'b0, v2_r[9]} * {36'b0, e_r[63:32]};
    prod     = {32'b0, slo_r} + {shi_r, 32'b0};
    hs_nxt   = prod[99:65];
    v3_nxt   = {v2_r[11][32:0], 31'b0} + {29'b0, hs_r};

    // Stages 13 to 17: full product v3*d and the final adjustment.
    a0_nxt   = {32'b0, v3_r[12][31:0]}  * {32'b0, d_r[12][31:0]};
    a1_nxt   = {32'b0, v3_r[12][31:0]}  * {32'b0, d_r[12][63:32]};
    a2_nxt   = {32'b0, v3_r[12][63:32]} * {32'b0, d_r[12][31:0]};
    a3_nxt   = {32'b0, v3_r[12][63:32]} * {32'b0, d_r[12][63:32]};
    mid_nxt  = {1'b0, a1_r} + {1'b0, a2_r};
    full_nxt = {a3c_r, a0c_r} + {31'b0, mid_r, 32'b0};
    lo_sum   = {1'b0, full_r[63:0]} + {1'b0, d_r[15]};
    hi_nxt   = full_r[127:64] + {63'b0, lo_sum[64]};
    res_nxt  = v3_r[16] - hi_r - d_r[16];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d_r[0]   <= in_chan.divisor;
      v0_r[0]  <= v0_nxt;
      d40_r[0] <= d40_nxt;
    end
    for (int k = 1; k <= 16; k++) begin
      if (en[k]) begin
        d_r[k] <= d_r[k-1];
      end
    end
    for (int k = 1; k <= 3; k++) begin
      if (en[k]) begin
        d40_r[k] <= d40_r[k-1];
      end
    end
    for (int k = 1; k <= 2; k++) begin
      if (en[k]) begin
        v0_r[k] <= v0_r[k-1];
      end
    end
    for (int k = 4; k <= 6; k++) begin
      if (en[k]) begin
        v1_r[k] <= v1_r[k-1];
      end
    end
    for (int k = 8; k <= 11; k++) begin
      if (en[k]) begin
        v2_r[k] <= v2_r[k-1];
      end
    end
    for (int k = 13; k <= 16; k++) begin
      if (en[k]) begin
        v3_r[k] <= v3_r[k-1];
      end
    end

    if (en[1]) begin
      sq_r <= sq_nxt;
    end
    if (en[2]) begin
      m_r <= m_nxt;
    end
    if (en[3]) begin
      v1_r[3] <= v1_nxt;
    end
    if (en[4]) begin
      p_r <= p_nxt;
    end
    if (en[5]) begin
      t_r <= t_nxt;
    end
    if (en[6]) begin
      qlo_r <= qlo_nxt;
      qhi_r <= qhi_nxt;
    end
    if (en[7]) begin
      v2_r[7] <= v2_nxt;
      d63_r   <= d63_nxt;
    end
    if (en[8]) begin
      rlo_r <= rlo_nxt;
      rhi_r <= rhi_nxt;
      hv_r  <= hv_nxt;
    end
    if (en[9]) begin
      e_r <= e_nxt;
    end
    if (en[10]) begin
      slo_r <= slo_nxt;
      shi_r <= shi_nxt;
    end
    if (en[11]) begin
      hs_r <= hs_nxt;
    end
    if (en[12]) begin
      v3_r[12] <= v3_nxt;
    end
    if (en[13]) begin
      a0_r <= a0_nxt;
      a1_r <= a1_nxt;
      a2_r <= a2_nxt;
      a3_r <= a3_nxt;
    end
    if (en[14]) begin
      mid_r <= mid_nxt;
      a0c_r <= a0_r;
      a3c_r <= a3_r;
    end
    if (en[15]) begin
      full_r <= full_nxt;
    end
    if (en[16]) begin
      hi_r <= hi_nxt;
    end
    if (en[17]) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid      = vld_r[NSTG-1];
  assign out_chan.reciprocal = res_r;

endmodule

`default_nettype wire
